[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the chained free block list.
// Expects a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property body, switched off while reset is asserted.
`define CFBL_PROP(prop) @(posedge clk_i) disable iff (!rst_ni) (prop)

// Named concurrent assertion that reports through $error.
`define CFBL_ASSERT(label, prop, msg) \
  label: assert property (`CFBL_PROP(prop)) else $error(msg);

`endif

[rtl/core/cfbl_pkg.sv]
// Package for the chained free block list: sizes, codes, and the command
// and status structs between controller and datapath. No dependencies.
`default_nettype none

package cfbl_pkg;

  localparam int FreeSlots = 32;
  localparam int BlockBits = 16;
  localparam int FieldW    = 16;
  localparam int CntW      = $clog2(FreeSlots + 1);
  localparam int AddrW     = $clog2(FreeSlots);

  localparam logic [FieldW-1:0] SlotsWord = FieldW'(FreeSlots);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_FILL  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_GRANT = 3'd0,
    KIND_FETCH = 3'd1,
    KIND_SPILL = 3'd2,
    KIND_DONE  = 3'd3,
    KIND_ERROR = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BUSY  = 2'd2,
    ST_BIG   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR,
    CNT_ONE
  } cnt_op_e;

  typedef enum logic [1:0] {
    WR_ZERO,
    WR_BLK,
    WR_FILL
  } wr_src_e;

  typedef enum logic [2:0] {
    FILL_HOLD,
    FILL_START,
    FILL_HDR,
    FILL_DEC,
    FILL_END
  } fill_op_e;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_CLR,
    IDX_INC
  } idx_op_e;

  typedef enum logic [2:0] {
    OUT_ERR,
    OUT_FETCH,
    OUT_GRANT_RD,
    OUT_GRANT_CHAIN,
    OUT_SPILL_HDR,
    OUT_SPILL_WORD,
    OUT_DONE
  } out_sel_e;

  typedef struct packed {
    logic     in_load;
    logic     rd_idx;
    logic     wr_en;
    wr_src_e  wr_src;
    cnt_op_e  cnt_op;
    fill_op_e fill_op;
    idx_op_e  idx_op;
    logic     out_load;
    out_sel_e out_sel;
    status_e  err_status;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic filling;
    logic header_seen;
    logic cnt_zero;
    logic cnt_one;
    logic cnt_full;
    logic rem_zero;
    logic rem_one;
    logic fill_big;
    logic fill_zero;
    logic rd_zero;
    logic idx_last;
    logic out_free;
  } dp_sts_t;

  // Block numbers are held in BlockBits bits and carried on the ports in
  // FieldW bits; these two helpers convert either way.
  function automatic logic [BlockBits-1:0] to_blk(logic [FieldW-1:0] x);
    logic [BlockBits-1:0] r;
    r = '0;
    for (int i = 0; i < BlockBits; i++) begin
      if (i < FieldW) begin
        r[i] = x[i];
      end
    end
    return r;
  endfunction

  function automatic logic [FieldW-1:0] to_field(logic [BlockBits-1:0] x);
    logic [FieldW-1:0] r;
    r = '0;
    for (int i = 0; i < FieldW; i++) begin
      if (i < BlockBits) begin
        r[i] = x[i];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/cfbl_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered. Self-contained, no package needed.
`default_nettype none

module cfbl_ram #(
  parameter int Width = 16,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/cfbl_dp.sv]
// Datapath of the chained free block list: input latch, stack RAM, counters,
// fill state and the output register. Uses cfbl_pkg and cfbl_ram.
`default_nettype none

module cfbl_dp
  import cfbl_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dp_cmd_t           cmd_i,
  output dp_sts_t                sts_o,
  input  wire logic [1:0]        in_op_i,
  input  wire logic [FieldW-1:0] in_blk_i,
  input  wire logic [FieldW-1:0] in_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [2:0]             out_kind_o,
  output logic [FieldW-1:0]      out_blk_o,
  output logic [FieldW-1:0]      out_word_o,
  output logic                   out_last_o,
  output logic [1:0]             out_status_o
);

  // Latched input transaction.
  op_e                  op_q;
  logic [BlockBits-1:0] blk_q;
  logic [FieldW-1:0]    word_q;

  // Stack bookkeeping.
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [CntW-1:0]      rem_q, rem_d;
  logic                 filling_q, filling_d;
  logic                 header_q, header_d;
  logic [BlockBits-1:0] chain_q, chain_d;
  logic [AddrW-1:0]     idx_q, idx_d;

  // Output register.
  logic                 ovalid_q, ovalid_d;
  kind_e                okind_q, okind_d;
  logic [FieldW-1:0]    oblk_q, oword_q;
  logic [FieldW-1:0]    oblk_d, oword_d;
  logic                 olast_q, olast_d;
  status_e              ostatus_q, ostatus_d;

  logic                 we;
  logic [AddrW-1:0]     waddr, raddr;
  logic [BlockBits-1:0] wdata, rdata;
  logic [CntW-1:0]      cnt_m1;

  assign cnt_m1 = cnt_q - CntW'(1);
  assign raddr  = cmd_i.rd_idx ? idx_q : cnt_m1[AddrW-1:0];
  assign we     = cmd_i.wr_en;

  always_comb begin
    unique case (cmd_i.wr_src)
      WR_BLK:  wdata = blk_q;
      WR_FILL: wdata = to_blk(word_q);
      default: wdata = '0;
    endcase
    waddr = (cmd_i.wr_src == WR_ZERO) ? '0 : cnt_q[AddrW-1:0];
  end

  cfbl_ram #(
    .Width (BlockBits),
    .Depth (FreeSlots)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      op_q   <= op_e'(in_op_i);
      blk_q  <= to_blk(in_blk_i);
      word_q <= in_word_i;
    end
  end

  always_comb begin
    unique case (cmd_i.cnt_op)
      CNT_INC: cnt_d = cnt_q + CntW'(1);
      CNT_DEC: cnt_d = cnt_m1;
      CNT_CLR: cnt_d = '0;
      CNT_ONE: cnt_d = CntW'(1);
      default: cnt_d = cnt_q;
    endcase

    filling_d = filling_q;
    header_d  = header_q;
    rem_d     = rem_q;
    chain_d   = chain_q;
    unique case (cmd_i.fill_op)
      FILL_START: begin
        filling_d = 1'b1;
        header_d  = 1'b0;
        rem_d     = '0;
        chain_d   = rdata;
      end
      FILL_HDR: begin
        header_d = 1'b1;
        rem_d    = word_q[CntW-1:0];
      end
      FILL_DEC: rem_d = rem_q - CntW'(1);
      FILL_END: begin
        filling_d = 1'b0;
        header_d  = 1'b0;
        rem_d     = '0;
      end
      default: ;
    endcase

    unique case (cmd_i.idx_op)
      IDX_CLR: idx_d = '0;
      IDX_INC: idx_d = idx_q + AddrW'(1);
      default: idx_d = idx_q;
    endcase

    if (cmd_i.out_load) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      rem_q     <= '0;
      filling_q <= 1'b0;
      header_q  <= 1'b0;
      chain_q   <= '0;
      idx_q     <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      rem_q     <= rem_d;
      filling_q <= filling_d;
      header_q  <= header_d;
      chain_q   <= chain_d;
      idx_q     <= idx_d;
      ovalid_q  <= ovalid_d;
    end
  end

  // Result payload; errors and non-spill results carry zero data.
  always_comb begin
    okind_d   = KIND_DONE;
    oblk_d    = to_field(blk_q);
    oword_d   = '0;
    olast_d   = 1'b1;
    ostatus_d = ST_OK;
    unique case (cmd_i.out_sel)
      OUT_ERR: begin
        okind_d   = KIND_ERROR;
        oblk_d    = '0;
        ostatus_d = cmd_i.err_status;
      end
      OUT_FETCH: begin
        okind_d = KIND_FETCH;
        oblk_d  = to_field(rdata);
      end
      OUT_GRANT_RD: begin
        okind_d = KIND_GRANT;
        oblk_d  = to_field(rdata);
      end
      OUT_GRANT_CHAIN: begin
        okind_d = KIND_GRANT;
        oblk_d  = to_field(chain_q);
      end
      OUT_SPILL_HDR: begin
        okind_d = KIND_SPILL;
        oword_d = SlotsWord;
        olast_d = 1'b0;
      end
      OUT_SPILL_WORD: begin
        okind_d = KIND_SPILL;
        oword_d = to_field(rdata);
        olast_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      okind_q   <= okind_d;
      oblk_q    <= oblk_d;
      oword_q   <= oword_d;
      olast_q   <= olast_d;
      ostatus_q <= ostatus_d;
    end
  end

  assign sts_o.op          = op_q;
  assign sts_o.filling     = filling_q;
  assign sts_o.header_seen = header_q;
  assign sts_o.cnt_zero    = (cnt_q == '0);
  assign sts_o.cnt_one     = (cnt_q == CntW'(1));
  assign sts_o.cnt_full    = (cnt_q >= CntW'(FreeSlots));
  assign sts_o.rem_zero    = (rem_q == '0);
  assign sts_o.rem_one     = (rem_q == CntW'(1));
  assign sts_o.fill_big    = (word_q > SlotsWord);
  assign sts_o.fill_zero   = (word_q == '0);
  assign sts_o.rd_zero     = (rdata == '0);
  assign sts_o.idx_last    = (idx_q == AddrW'(FreeSlots - 1));
  assign sts_o.out_free    = !ovalid_q || out_ready_i;

  assign out_valid_o  = ovalid_q;
  assign out_kind_o   = okind_q;
  assign out_blk_o    = oblk_q;
  assign out_word_o   = oword_q;
  assign out_last_o   = olast_q;
  assign out_status_o = ostatus_q;

endmodule

`default_nettype wire

[rtl/core/cfbl_ctrl.sv]
// Controller of the chained free block list: decodes each transaction and
// sequences pops, pushes and spills. Uses cfbl_pkg; drives cfbl_dp.
`default_nettype none

module cfbl_ctrl
  import cfbl_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_AEVAL = 3'd2;
  localparam logic [2:0] S_SRD   = 3'd3;
  localparam logic [2:0] S_SWORD = 3'd4;
  localparam logic [2:0] S_MARK  = 3'd5;
  localparam logic [2:0] S_PUSH  = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '{
      in_load:    1'b0,
      rd_idx:     1'b0,
      wr_en:      1'b0,
      wr_src:     WR_ZERO,
      cnt_op:     CNT_HOLD,
      fill_op:    FILL_HOLD,
      idx_op:     IDX_HOLD,
      out_load:   1'b0,
      out_sel:    OUT_ERR,
      err_status: ST_OK
    };

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = S_DISP;
        end
      end

      // Every decision waits for a free output register, so that any
      // state change and its result happen in the same cycle.
      S_DISP: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
          unique case (sts_i.op)
            OP_ALLOC: begin
              if (sts_i.filling) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.err_status = ST_BUSY;
              end else if (sts_i.cnt_zero) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.err_status = ST_EMPTY;
              end else begin
                state_d = S_AEVAL;
              end
            end
            OP_FREE: begin
              if (sts_i.filling) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.err_status = ST_BUSY;
              end else if (sts_i.cnt_full) begin
                cmd_o.out_load = 1'b1;
                cmd_o.out_sel  = OUT_SPILL_HDR;
                cmd_o.idx_op   = IDX_CLR;
                state_d        = S_SRD;
              end else if (sts_i.cnt_zero) begin
                state_d = S_MARK;
              end else begin
                state_d = S_PUSH;
              end
            end
            OP_FILL: begin
              if (!sts_i.filling) begin
                state_d = S_IDLE;
              end else if (!sts_i.header_seen) begin
                if (sts_i.fill_big) begin
                  cmd_o.fill_op    = FILL_END;
                  cmd_o.cnt_op     = CNT_CLR;
                  cmd_o.out_load   = 1'b1;
                  cmd_o.err_status = ST_BIG;
                end else begin
                  cmd_o.cnt_op = CNT_CLR;
                  if (sts_i.fill_zero) begin
                    // A table with no entries completes the load at once.
                    cmd_o.fill_op  = FILL_END;
                    cmd_o.out_load = 1'b1;
                    cmd_o.out_sel  = OUT_GRANT_CHAIN;
                  end else begin
                    cmd_o.fill_op = FILL_HDR;
                  end
                end
              end else if (sts_i.rem_zero) begin
                cmd_o.fill_op  = FILL_END;
                cmd_o.out_load = 1'b1;
                cmd_o.out_sel  = OUT_GRANT_CHAIN;
              end else if (!sts_i.cnt_full) begin
                cmd_o.wr_en  = 1'b1;
                cmd_o.wr_src = WR_FILL;
                cmd_o.cnt_op = CNT_INC;
                if (sts_i.rem_one) begin
                  cmd_o.fill_op  = FILL_END;
                  cmd_o.out_load = 1'b1;
                  cmd_o.out_sel  = OUT_GRANT_CHAIN;
                end else begin
                  cmd_o.fill_op = FILL_DEC;
                end
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      // Read data for the top entry is valid here.
      S_AEVAL: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
          if (sts_i.rd_zero) begin
            cmd_o.err_status = ST_EMPTY;
          end else if (sts_i.cnt_one) begin
            cmd_o.cnt_op  = CNT_DEC;
            cmd_o.fill_op = FILL_START;
            cmd_o.out_sel = OUT_FETCH;
          end else begin
            cmd_o.cnt_op  = CNT_DEC;
            cmd_o.out_sel = OUT_GRANT_RD;
          end
        end
      end

      S_SRD: begin
        cmd_o.rd_idx = 1'b1;
        state_d      = S_SWORD;
      end

      S_SWORD: begin
        cmd_o.rd_idx = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OUT_SPILL_WORD;
          cmd_o.idx_op   = IDX_INC;
          if (sts_i.idx_last) begin
            cmd_o.cnt_op = CNT_CLR;
            state_d      = S_MARK;
          end else begin
            state_d = S_SRD;
          end
        end
      end

      S_MARK: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_src = WR_ZERO;
        cmd_o.cnt_op = CNT_ONE;
        state_d      = S_PUSH;
      end

      S_PUSH: begin
        if (sts_i.out_free) begin
          cmd_o.wr_en    = 1'b1;
          cmd_o.wr_src   = WR_BLK;
          cmd_o.cnt_op   = CNT_INC;
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OUT_DONE;
          state_d        = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/chained_free_block_list.sv]
// Top level of the chained free block list: stream ports, controller and
// datapath. Uses cfbl_pkg, cfbl_ctrl, cfbl_dp and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// The block keeps a stack of up to 32 free block numbers in a small RAM and
// backs it with chain tables held in external storage. An allocate pops the
// top number and grants it; a popped zero is the end-of-chain marker and
// answers with an empty error while the marker stays in place. When a pop
// takes the last entry, that block is a chain block: the block asks for its
// table with a fetch request, is then fed fill transactions (first the entry
// count, then the entries bottom up) and grants the chain block once the
// last entry is loaded, or right on the count when the table is empty. A
// fill count above 32 abandons the load with an error and leaves the stack
// empty. Allocate and free while a load is in
// progress are refused with a busy error, and fill words that arrive while
// no load is pending are dropped. A free onto an empty stack first places a
// zero end marker, then pushes the block. A free onto a full stack first
// writes the stack out as 33 spill results (the count, then all entries
// bottom up) addressed to the block being freed, then starts a new stack
// with the end marker and that block. Every transaction ends with exactly
// one result with tlast high, except fill words that complete nothing and
// unused operation codes, which give no result. The block handles one
// transaction at a time: tready is high only while it is idle. Each spill
// word is a registered RAM read (state S_SRD, then S_SWORD) that must land
// in the single output register. Results wait in that output register, so
// the next transaction is taken while the last result is still held by
// back pressure; further back pressure simply stretches each sequence.
module chained_free_block_list
  import cfbl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input transactions.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,  // [15:0] block_number, [31:16] fill_word
  input  wire logic [1:0]  s_axis_tuser_i,  // [1:0] operation
  // Result transactions.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,  // [15:0] block_number_res, [31:16] data_word
  output logic [4:0]       m_axis_tuser_o,  // [2:0] kind, [4:3] status
  output logic             m_axis_tlast_o
);

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [2:0]        out_kind;
  logic [1:0]        out_status;
  logic [FieldW-1:0] out_blk, out_word;

  cfbl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cfbl_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_op_i      (s_axis_tuser_i),
    .in_blk_i     (s_axis_tdata_i[15:0]),
    .in_word_i    (s_axis_tdata_i[31:16]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_kind_o   (out_kind),
    .out_blk_o    (out_blk),
    .out_word_o   (out_word),
    .out_last_o   (m_axis_tlast_o),
    .out_status_o (out_status)
  );

  assign m_axis_tdata_o = {out_word, out_blk};
  assign m_axis_tuser_o = {out_status, out_kind};

  // An accepted transaction always makes the block busy in the next cycle.
  `CFBL_ASSERT(a_busy_after_accept,
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o,
    "block took a transaction while still working")

  // Only spill words may leave tlast low.
  `CFBL_ASSERT(a_nonlast_is_spill,
    (m_axis_tvalid_o && !m_axis_tlast_o) |-> (m_axis_tuser_o[2:0] == KIND_SPILL),
    "result without tlast is not a spill word")

  // A new result only appears after work on a transaction, not from idle.
  `CFBL_ASSERT(a_result_from_work,
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o),
    "result appeared while the block was idle")

  // Outside a table load, the stack count never runs past its capacity.
  `CFBL_ASSERT(a_count_bound,
    (sts.cnt_full && !sts.filling) |-> !(cmd.cnt_op == CNT_INC),
    "stack count would exceed its capacity")

endmodule

`default_nettype wire
